/* rtl/tcc_pkg.sv */
// Shared types and constants of the text console cursor engine.
// Used by the channel interfaces and every module of the block; no dependencies.
package tcc_pkg;

    localparam int CELL_W = 16;
    localparam int ATTR_W = 8;
    localparam int CHAR_W = 8;
    localparam int OP_W = 2;
    localparam int PORT_ADDR_W = 11;

    localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

    typedef enum logic [OP_W-1:0] {
        OP_PUT = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ = 2'd2
    } opcode_t;

    typedef struct packed {
        logic start;
        logic scroll;
        logic [ATTR_W-1:0] attr;
    } sweep_cmd_t;

endpackage

/* rtl/tcc_in_if.sv */
// Command channel of the text console cursor engine.
// Depends on tcc_pkg for the field widths.
interface tcc_in_if;
    logic valid;
    logic ready;
    logic [tcc_pkg::OP_W-1:0] opcode;
    logic [tcc_pkg::CHAR_W-1:0] char_code;
    logic [tcc_pkg::PORT_ADDR_W-1:0] cell_address;

    modport source (output valid, opcode, char_code, cell_address, input ready);
    modport sink (input valid, opcode, char_code, cell_address, output ready);
endinterface

/* rtl/tcc_out_if.sv */
// Result channel of the text console cursor engine.
// Depends on tcc_pkg for the field widths.
interface tcc_out_if;
    logic valid;
    logic ready;
    logic [tcc_pkg::CELL_W-1:0] cell_value;
    logic [tcc_pkg::PORT_ADDR_W-1:0] cursor_position;
    logic cursor_moved;

    modport source (output valid, cell_value, cursor_position, cursor_moved, input ready);
    modport sink (input valid, cell_value, cursor_position, cursor_moved, output ready);
endinterface

/* rtl/tcc_cfg_if.sv */
// Configuration write channel carrying the text attribute register.
// Depends on tcc_pkg for the data width.
interface tcc_cfg_if;
    logic valid;
    logic ready;
    logic [tcc_pkg::ATTR_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

/* rtl/tcc_screen_ram.sv */
// Screen cell memory: one write port and one registered read port.
// Depends on tcc_pkg for the cell width.
module tcc_screen_ram #(
    parameter int DEPTH = 2000,
    parameter int AW = 11
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [tcc_pkg::CELL_W-1:0]  wr_data,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [tcc_pkg::CELL_W-1:0]  rd_data
);

    logic [tcc_pkg::CELL_W-1:0] mem [DEPTH];
    logic [tcc_pkg::CELL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/tcc_sweep.sv */
// Sequencer that walks every screen cell for clear, scroll and the pass after reset.
// Depends on tcc_pkg; drives the read and write ports of tcc_screen_ram.
module tcc_sweep #(
    parameter int COLUMNS = 80,
    parameter int CELL_TOTAL = 2000,
    parameter int AW = 11
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tcc_pkg::sweep_cmd_t         cmd,
    output logic                        busy,
    output logic                        rd_en,
    output logic [AW-1:0]               rd_addr,
    input  logic [tcc_pkg::CELL_W-1:0]  rd_data,
    output logic                        wr_en,
    output logic [AW-1:0]               wr_addr,
    output logic [tcc_pkg::CELL_W-1:0]  wr_data
);

    localparam logic [AW-1:0] COL_A = AW'(COLUMNS);
    localparam logic [AW-1:0] COPY_END = AW'(CELL_TOTAL - COLUMNS);
    localparam logic [AW-1:0] LAST_IDX = AW'(CELL_TOTAL - 1);

    logic                        active_reg;
    logic                        scroll_reg;
    logic [tcc_pkg::ATTR_W-1:0]  attr_reg;
    logic [AW-1:0]               idx_reg;
    logic                        wvalid_reg;
    logic [AW-1:0]               waddr_reg;
    logic                        wcopy_reg;
    logic                        copy_now;

    assign copy_now = scroll_reg && (idx_reg < COPY_END);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b1;
            scroll_reg <= 1'b0;
            attr_reg <= tcc_pkg::RESET_ATTR;
            idx_reg <= '0;
            wvalid_reg <= 1'b0;
        end
        else
        begin
            wvalid_reg <= active_reg;
            if (cmd.start)
            begin
                active_reg <= 1'b1;
                scroll_reg <= cmd.scroll;
                attr_reg <= cmd.attr;
                idx_reg <= '0;
            end
            else if (active_reg)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    active_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        waddr_reg <= idx_reg;
        wcopy_reg <= copy_now;
    end

    assign busy = active_reg | wvalid_reg;
    assign rd_en = active_reg && copy_now;
    assign rd_addr = idx_reg + COL_A;
    assign wr_en = wvalid_reg;
    assign wr_addr = waddr_reg;
    assign wr_data = wcopy_reg ? rd_data : {attr_reg, tcc_pkg::BLANK_CHAR};

endmodule

/* rtl/text_console_cursor_engine.sv */
// Text console: a screen of attribute/character cells in one RAM, a cursor, and a cell
// read port. Put, clear and unused commands return their result in the cycle after
// acceptance; a read goes to ST_READ while the RAM reads the cell, and its result is
// registered from there. A clear, or a put or newline that runs past the last row,
// then walks all COLUMNS*ROW_COUNT cells through the RAM's single read and write port,
// one cell a cycle, and no item is taken until the walk is done. The same walk, taking no
// item, blanks the screen to 0x0F20 after reset. Configuration writes are always taken.
module text_console_cursor_engine #(
    parameter int COLUMNS = 80,
    parameter int ROW_COUNT = 25
) (
    input  logic       clk,
    input  logic       rst_n,
    tcc_in_if.sink     cmd,
    tcc_out_if.source  rsp,
    tcc_cfg_if.sink    cfg
);

    localparam int CELL_TOTAL = COLUMNS * ROW_COUNT;
    localparam int AW = $clog2(CELL_TOTAL);
    localparam int CW = $clog2(COLUMNS);
    localparam int RW = $clog2(ROW_COUNT);
    localparam int PW = tcc_pkg::PORT_ADDR_W;
    localparam logic [AW-1:0] COL_A = AW'(COLUMNS);
    localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] LAST_ROW = RW'(ROW_COUNT - 1);
    localparam logic [PW+1:0] TOTAL_X = (PW + 2)'(CELL_TOTAL);

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    state_t                        state_reg, state_next;
    logic [tcc_pkg::ATTR_W-1:0]    attr_reg;
    logic [CW-1:0]                 col_reg, col_next;
    logic [RW-1:0]                 row_reg, row_next;
    logic                          out_valid_reg, out_valid_next;
    logic [tcc_pkg::CELL_W-1:0]    out_value_reg, out_value_next;
    logic [PW-1:0]                 out_pos_reg, out_pos_next;
    logic                          out_moved_reg, out_moved_next;
    logic                          in_range_reg, in_range_next;

    logic                          accept;
    logic                          advance_row;
    logic [AW-1:0]                 pos_cur;
    logic [AW-1:0]                 pos_new;
    tcc_pkg::sweep_cmd_t           sweep_cmd;
    logic                          sweep_busy;
    logic                          sw_rd_en, sw_wr_en;
    logic [AW-1:0]                 sw_rd_addr, sw_wr_addr;
    logic [tcc_pkg::CELL_W-1:0]    sw_wr_data;
    logic                          put_wr_en, rd_cmd_en;
    logic                          ram_wr_en, ram_rd_en;
    logic [AW-1:0]                 ram_wr_addr, ram_rd_addr;
    logic [tcc_pkg::CELL_W-1:0]    ram_wr_data, ram_rd_data;

    assign cmd.ready = (state_reg == ST_IDLE) && !sweep_busy && (!out_valid_reg || rsp.ready);
    assign accept = cmd.valid && cmd.ready;
    assign cfg.ready = 1'b1;

    assign pos_cur = AW'(row_reg) * COL_A + AW'(col_reg);
    assign pos_new = AW'(row_next) * COL_A + AW'(col_next);

    always_comb
    begin
        state_next = state_reg;
        col_next = col_reg;
        row_next = row_reg;
        advance_row = 1'b0;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_value_next = out_value_reg;
        out_pos_next = out_pos_reg;
        out_moved_next = out_moved_reg;
        in_range_next = in_range_reg;
        sweep_cmd = '{start: 1'b0, scroll: 1'b0, attr: attr_reg};
        put_wr_en = 1'b0;
        rd_cmd_en = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.opcode)
                        tcc_pkg::OP_PUT:
                        begin
                            if (cmd.char_code == tcc_pkg::NEWLINE_CHAR)
                            begin
                                advance_row = 1'b1;
                            end
                            else
                            begin
                                put_wr_en = 1'b1;
                                if (col_reg == LAST_COL)
                                begin
                                    advance_row = 1'b1;
                                end
                                else
                                begin
                                    col_next = col_reg + 1'b1;
                                end
                            end
                            if (advance_row)
                            begin
                                col_next = '0;
                                if (row_reg == LAST_ROW)
                                begin
                                    sweep_cmd.start = 1'b1;
                                    sweep_cmd.scroll = 1'b1;
                                end
                                else
                                begin
                                    row_next = row_reg + 1'b1;
                                end
                            end
                        end
                        tcc_pkg::OP_CLEAR:
                        begin
                            col_next = '0;
                            row_next = '0;
                            sweep_cmd.start = 1'b1;
                        end
                        tcc_pkg::OP_READ:
                        begin
                            rd_cmd_en = 1'b1;
                            in_range_next = {2'b00, cmd.cell_address} < TOTAL_X;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                    if (cmd.opcode != tcc_pkg::OP_READ)
                    begin
                        out_valid_next = 1'b1;
                        out_value_next = '0;
                        out_pos_next = PW'(pos_new);
                        out_moved_next = put_wr_en;
                    end
                end
            end
            ST_READ:
            begin
                out_valid_next = 1'b1;
                out_value_next = in_range_reg ? ram_rd_data : '0;
                out_pos_next = PW'(pos_cur);
                out_moved_next = 1'b0;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            attr_reg <= tcc_pkg::RESET_ATTR;
            col_reg <= '0;
            row_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg <= col_next;
            row_reg <= row_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                attr_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        out_pos_reg <= out_pos_next;
        out_moved_reg <= out_moved_next;
        in_range_reg <= in_range_next;
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.cell_value = out_value_reg;
    assign rsp.cursor_position = out_pos_reg;
    assign rsp.cursor_moved = out_moved_reg;

    assign ram_wr_en = sw_wr_en | put_wr_en;
    assign ram_wr_addr = sw_wr_en ? sw_wr_addr : pos_cur;
    assign ram_wr_data = sw_wr_en ? sw_wr_data : {attr_reg, cmd.char_code};
    assign ram_rd_en = sw_rd_en | rd_cmd_en;
    assign ram_rd_addr = sw_rd_en ? sw_rd_addr : AW'(cmd.cell_address);

    tcc_sweep #(
        .COLUMNS(COLUMNS),
        .CELL_TOTAL(CELL_TOTAL),
        .AW(AW)
    ) u_sweep (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(sweep_cmd),
        .busy(sweep_busy),
        .rd_en(sw_rd_en),
        .rd_addr(sw_rd_addr),
        .rd_data(ram_rd_data),
        .wr_en(sw_wr_en),
        .wr_addr(sw_wr_addr),
        .wr_data(sw_wr_data)
    );

    tcc_screen_ram #(
        .DEPTH(CELL_TOTAL),
        .AW(AW)
    ) u_ram (
        .clk(clk),
        .wr_en(ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_en(ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

endmodule

/* test/testbench.sv */
// Self-checking testbench for the text console cursor engine: random and directed commands,
// a cycle-free screen predictor in a scoreboard class, and random stalls on both channels.
// Depends on tcc_pkg and the cmd, rsp and cfg channel interfaces of the RTL.
package console_tb_pkg;
    localparam int COLUMNS = 80;
    localparam int ROW_COUNT = 25;
    localparam int CELL_TOTAL = COLUMNS * ROW_COUNT;
    localparam logic [tcc_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [tcc_pkg::CELL_W-1:0] cell_value;
        logic [tcc_pkg::PORT_ADDR_W-1:0] cursor_position;
        logic cursor_moved;
    } console_response_t;

    class console_scoreboard_t;
        logic [tcc_pkg::CELL_W-1:0] screen [CELL_TOTAL];
        logic [tcc_pkg::ATTR_W-1:0] attribute;
        int column;
        int row;
        console_response_t pending_responses[$];
        int failures;
        int checked;
        int puts;
        int newlines;
        int clears;
        int reads;
        int reads_out_of_range;
        int unused;
        int scrolls;
        int wraps;

        function new();
            attribute = tcc_pkg::RESET_ATTR;
            blank_screen();
            column = 0;
            row = 0;
        endfunction

        function void blank_screen();
            foreach (screen[i])
                screen[i] = {attribute, tcc_pkg::BLANK_CHAR};
        endfunction

        function int cursor_linear();
            return row * COLUMNS + column;
        endfunction

        function void move_to_next_row();
            column = 0;
            row++;
            if (row < ROW_COUNT)
                return;
            scrolls++;
            for (int i = 0; i < CELL_TOTAL - COLUMNS; i++)
                screen[i] = screen[i + COLUMNS];
            for (int i = CELL_TOTAL - COLUMNS; i < CELL_TOTAL; i++)
                screen[i] = {attribute, tcc_pkg::BLANK_CHAR};
            row = ROW_COUNT - 1;
        endfunction

        function void note_command(logic [tcc_pkg::OP_W-1:0] op,
                                   logic [tcc_pkg::CHAR_W-1:0] ch,
                                   logic [tcc_pkg::PORT_ADDR_W-1:0] addr);
            console_response_t resp;
            resp.cell_value = '0;
            resp.cursor_moved = 1'b0;
            case (op)
                tcc_pkg::OP_PUT:
                begin
                    if (ch == tcc_pkg::NEWLINE_CHAR)
                    begin
                        newlines++;
                        move_to_next_row();
                    end
                    else
                    begin
                        puts++;
                        screen[cursor_linear()] = {attribute, ch};
                        column++;
                        if (column >= COLUMNS)
                        begin
                            wraps++;
                            move_to_next_row();
                        end
                        resp.cursor_moved = 1'b1;
                    end
                end
                tcc_pkg::OP_CLEAR:
                begin
                    clears++;
                    blank_screen();
                    column = 0;
                    row = 0;
                end
                tcc_pkg::OP_READ:
                begin
                    reads++;
                    if (addr < CELL_TOTAL)
                        resp.cell_value = screen[addr];
                    else
                        reads_out_of_range++;
                end
                default:
                    unused++;
            endcase
            resp.cursor_position = tcc_pkg::PORT_ADDR_W'(cursor_linear());
            pending_responses.push_back(resp);
        endfunction

        function void check_response(logic [tcc_pkg::CELL_W-1:0] value,
                                     logic [tcc_pkg::PORT_ADDR_W-1:0] pos, logic moved);
            console_response_t want;
            checked++;
            if (pending_responses.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("Unexpected response %0d: value %h position %0d moved %0d",
                             checked, value, pos, moved);
                return;
            end
            want = pending_responses.pop_front();
            if (value !== want.cell_value || pos !== want.cursor_position
                    || moved !== want.cursor_moved)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display("Mismatch on response %0d: expected value %h position %0d moved %0d",
                             checked, want.cell_value, want.cursor_position, want.cursor_moved);
                    $display("    got value %h position %0d moved %0d", value, pos, moved);
                end
            end
        endfunction
    endclass
endpackage

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLUMNS = console_tb_pkg::COLUMNS;
    localparam int ROW_COUNT = console_tb_pkg::ROW_COUNT;
    localparam int CELL_TOTAL = console_tb_pkg::CELL_TOTAL;
    localparam int OP_W = tcc_pkg::OP_W;
    localparam int CHAR_W = tcc_pkg::CHAR_W;
    localparam int ATTR_W = tcc_pkg::ATTR_W;
    localparam int PORT_ADDR_W = tcc_pkg::PORT_ADDR_W;
    localparam int LONG_HOLD = 400;

    logic clk = 1'b0;
    logic rst_n;
    bit steady_flow;
    bit hold_request;
    int commands_sent;
    int attribute_settings;
    console_tb_pkg::console_scoreboard_t sb = new();

    tcc_in_if cmd_ch();
    tcc_out_if rsp_ch();
    tcc_cfg_if cfg_ch();

    text_console_cursor_engine #(
        .COLUMNS(COLUMNS),
        .ROW_COUNT(ROW_COUNT)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd_ch),
        .rsp(rsp_ch),
        .cfg(cfg_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int stall_length();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    function automatic int sender_gap();
        if (steady_flow)
            return 0;
        return ($urandom_range(0, 2) == 0) ? stall_length() : 0;
    endfunction

    function automatic logic [PORT_ADDR_W-1:0] read_target();
        int pick;
        int base;
        int back;
        pick = $urandom_range(0, 9);
        base = sb.cursor_linear();
        back = $urandom_range(1, 160);
        if (pick < 5 && base >= back)
            return PORT_ADDR_W'(base - back);
        if (pick < 8)
            return PORT_ADDR_W'($urandom_range(0, CELL_TOTAL - 1));
        if (pick == 8)
            return PORT_ADDR_W'($urandom_range(CELL_TOTAL, 2047));
        return PORT_ADDR_W'($urandom_range(0, 2047));
    endfunction

    task automatic send_command(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                                input logic [PORT_ADDR_W-1:0] addr);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.opcode <= op;
        cmd_ch.char_code <= ch;
        cmd_ch.cell_address <= addr;
        do @(posedge clk); while (!cmd_ch.ready);
        sb.note_command(op, ch, addr);
        commands_sent++;
    endtask

    task automatic put_char(input logic [CHAR_W-1:0] ch);
        send_command(tcc_pkg::OP_PUT, ch, PORT_ADDR_W'($urandom_range(0, 2047)));
    endtask

    task automatic read_cell(input logic [PORT_ADDR_W-1:0] addr);
        send_command(tcc_pkg::OP_READ, CHAR_W'($urandom_range(0, 255)), addr);
    endtask

    task automatic wait_until_idle();
        cmd_ch.valid <= 1'b0;
        while (sb.pending_responses.size() != 0)
            @(posedge clk);
        repeat (CELL_TOTAL + 20) @(posedge clk);
    endtask

    task automatic write_attribute(input logic [ATTR_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        sb.attribute = value;
        attribute_settings++;
    endtask

    task automatic send_text_line();
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(70, 90) : $urandom_range(1, 8);
        repeat (len) put_char(CHAR_W'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) < 7)
            put_char(tcc_pkg::NEWLINE_CHAR);
    endtask

    task automatic fill_page();
        for (int i = 0; i <= ROW_COUNT; i++)
        begin
            if (i % 4 == 0)
                put_char(CHAR_W'($urandom_range(0, 255)));
            put_char(tcc_pkg::NEWLINE_CHAR);
        end
    endtask

    task automatic stall_receiver_under_load();
        steady_flow = 1'b1;
        hold_request = 1'b1;
        repeat (6)
        begin
            put_char(CHAR_W'($urandom_range(0, 255)));
            read_cell(read_target());
        end
        steady_flow = 1'b0;
    endtask

    task automatic run_session(input int quota);
        int start;
        int pick;
        start = commands_sent;
        while (commands_sent - start < quota)
        begin
            pick = $urandom_range(0, 99);
            steady_flow = ($urandom_range(0, 4) == 0);
            if (pick < 40)
                send_text_line();
            else if (pick < 55)
                repeat ($urandom_range(1, 8)) put_char(tcc_pkg::NEWLINE_CHAR);
            else if (pick < 75)
                repeat ($urandom_range(1, 4)) read_cell(read_target());
            else if (pick < 78)
                send_command(tcc_pkg::OP_CLEAR, CHAR_W'($urandom_range(0, 255)),
                             PORT_ADDR_W'($urandom_range(0, 2047)));
            else if (pick < 84)
                send_command(console_tb_pkg::OP_UNUSED, CHAR_W'($urandom_range(0, 255)),
                             PORT_ADDR_W'($urandom_range(0, 2047)));
            else
                send_command(OP_W'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                             PORT_ADDR_W'($urandom_range(0, 2047)));
        end
        steady_flow = 1'b0;
    endtask

    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && stall_left == 0)
            begin
                stall_left = LONG_HOLD;
                hold_request = 1'b0;
            end
            else if (stall_left == 0 && !steady_flow && $urandom_range(0, 3) == 0)
                stall_left = stall_length();
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.cell_value, rsp_ch.cursor_position, rsp_ch.cursor_moved);
    end

    initial
    begin
        #50ms;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.opcode = tcc_pkg::OP_PUT;
        cmd_ch.char_code = '0;
        cmd_ch.cell_address = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        read_cell(PORT_ADDR_W'(0));
        read_cell(PORT_ADDR_W'(CELL_TOTAL - 1));
        read_cell(PORT_ADDR_W'(CELL_TOTAL));
        read_cell(PORT_ADDR_W'(2047));
        put_char(8'h00);
        put_char(8'hFF);
        put_char(8'h7F);
        put_char(tcc_pkg::BLANK_CHAR);
        read_cell(PORT_ADDR_W'(1));
        put_char(tcc_pkg::NEWLINE_CHAR);
        put_char(8'h41);
        read_cell(PORT_ADDR_W'(COLUMNS));
        read_cell(PORT_ADDR_W'(COLUMNS + 1));
        send_command(console_tb_pkg::OP_UNUSED, 8'hFF, 11'h7FF);
        send_command(console_tb_pkg::OP_UNUSED, 8'h00, 11'h000);
        send_command(tcc_pkg::OP_CLEAR, 8'hFF, 11'h7FF);
        read_cell(PORT_ADDR_W'(COLUMNS));
        put_char(tcc_pkg::NEWLINE_CHAR);
        put_char(8'h80);
        read_cell(PORT_ADDR_W'(COLUMNS));

        wait_until_idle();
        write_attribute(8'h00);
        fill_page();
        run_session(60);

        wait_until_idle();
        write_attribute(8'hFF);
        stall_receiver_under_load();
        run_session(60);

        wait_until_idle();
        write_attribute(ATTR_W'($urandom_range(1, 254)));
        run_session(60);

        wait_until_idle();
        write_attribute(ATTR_W'($urandom_range(0, 255)));
        stall_receiver_under_load();
        run_session(50);

        wait_until_idle();

        $display("Run covered %0d commands: %0d characters, %0d newlines, %0d clears, %0d reads",
                 commands_sent, sb.puts, sb.newlines, sb.clears, sb.reads);
        $display("(%0d out of range), %0d unused, %0d scrolls, %0d row wraps, %0d attributes.",
                 sb.reads_out_of_range, sb.unused, sb.scrolls, sb.wraps, attribute_settings);
        if (sb.failures == 0 && sb.pending_responses.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
